>>> rtl/core/masked_region_band_statistics_defines.svh
// Assertion helpers for the checker file.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef MASKED_REGION_BAND_STATISTICS_DEFINES_SVH
`define MASKED_REGION_BAND_STATISTICS_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define MRBS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off during reset.
`define MRBS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/mrbs_pkg.sv
package mrbs_pkg;

	// default field widths
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int COUNT_BITS_DEF  = 20;

	// accumulator -> finalizer: region closed, and whether it went over budget
	typedef struct packed {
		logic start;
		logic over;
	} mrbs_ctl_t;

	// finalizer -> output stage: result word is ready, statistics forced to zero
	typedef struct packed {
		logic load;
		logic zero;
	} mrbs_res_t;

	// round a bit count up to whole bytes
	function automatic int byte_width(input int bits);
		return ((bits + 7) >> 3) << 3;
	endfunction

endpackage

>>> rtl/core/masked_region_band_statistics.sv
// Masked region band statistics.
// Input stream s_*: one pixel word per handshake; s_tdata holds the signed sample,
// s_tuser the no-data flag, s_tlast closes the region. Output stream m_*: one result
// word per region, m_tuser is the over-budget status. cfg_* writes the pixel budget
// (0 or above 2^COUNT_BITS means 2^COUNT_BITS); write it only while the block is idle.
// Each pixel goes through accept, square/compare and add; s_tready is low between.
// After the last pixel the result word is worked out by the bit-per-cycle shift-add
// multiplies, restoring divides and square root on the one shared add/sub unit.
// An over-budget or all no-data region skips that work and goes straight to output.
// The result sits in an output register, so pixels of the next region are taken while
// it waits; a further result waits in the finalizer until the register is free, and
// the pixel input stays stalled meanwhile.
// Reset clears all statistics, drops m_tvalid and sets the budget to 2^COUNT_BITS.
module masked_region_band_statistics #(
	parameter int SAMPLE_BITS = mrbs_pkg::SAMPLE_BITS_DEF,
	parameter int COUNT_BITS  = mrbs_pkg::COUNT_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	// s_tdata: sample_value
	input  logic [mrbs_pkg::byte_width(SAMPLE_BITS)-1:0] s_tdata,
	// s_tuser: no_data
	input  logic s_tuser,
	input  logic s_tlast,
	input  logic s_tvalid,
	output logic s_tready,
	// m_tdata: valid_count, min_value, max_value, mean_value, std_dev
	output logic [mrbs_pkg::byte_width(COUNT_BITS + 1 + 4 * SAMPLE_BITS + 16)-1:0] m_tdata,
	// m_tuser: status
	output logic m_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	input  logic [COUNT_BITS:0] cfg_data,
	input  logic cfg_valid,
	output logic cfg_ready
);
	import mrbs_pkg::*;

	localparam int CW   = COUNT_BITS + 1;
	localparam int SUMW = SAMPLE_BITS + CW;
	localparam int SQSW = 2 * SAMPLE_BITS + COUNT_BITS - 1;
	localparam int RTW  = SAMPLE_BITS + 8;
	localparam int ODW  = byte_width(CW + 4 * SAMPLE_BITS + 16);

	logic [CW-1:0]                 budget_q;
	logic [CW-1:0]                 budget_eff;
	logic [CW-1:0]                 budget_max;
	mrbs_ctl_t                     ctl;
	mrbs_res_t                     res;
	logic [CW-1:0]                 good_count;
	logic signed [SAMPLE_BITS-1:0] run_min;
	logic signed [SAMPLE_BITS-1:0] run_max;
	logic signed [SUMW-1:0]        run_sum;
	logic [SQSW-1:0]               run_sqsum;
	logic [RTW-1:0]                mean_value;
	logic [RTW-1:0]                std_dev;
	logic                          out_free;
	logic [ODW-1:0]                m_tdata_q;
	logic                          m_tuser_q;
	logic                          m_tvalid_q;

	assign budget_max = CW'(1) << COUNT_BITS;

	// budget register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= CW'(1) << COUNT_BITS;
		end else if (cfg_valid) begin
			budget_q <= cfg_data;
		end
	end

	// zero or out-of-range budget falls back to the maximum
	assign budget_eff = ((budget_q == '0) || (budget_q > budget_max)) ? budget_max : budget_q;

	mrbs_accum #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.COUNT_BITS  (COUNT_BITS)
	) u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.sample_value (s_tdata[SAMPLE_BITS-1:0]),
		.no_data      (s_tuser),
		.last_pixel   (s_tlast),
		.budget       (budget_eff),
		.clear        (res.load),
		.ctl          (ctl),
		.good_count   (good_count),
		.run_min      (run_min),
		.run_max      (run_max),
		.run_sum      (run_sum),
		.run_sqsum    (run_sqsum)
	);

	mrbs_finalize #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.COUNT_BITS  (COUNT_BITS)
	) u_finalize (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.n          (good_count),
		.run_sum    (run_sum),
		.run_sqsum  (run_sqsum),
		.out_free   (out_free),
		.res        (res),
		.mean_value (mean_value),
		.std_dev    (std_dev)
	);

	// output register
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res.load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.load) begin
			m_tuser_q <= ctl.over;
			m_tdata_q <= res.zero ? '0 :
			             ODW'({std_dev, mean_value, run_max, run_min, good_count});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

>>> rtl/core/mrbs_addsub.sv
// Shared add/subtract unit; cout on subtract means a >= b.
module mrbs_addsub #(
	parameter int W = 8
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic         sub,
	output logic [W-1:0] res,
	output logic         cout
);

	logic [W:0] total;

	assign total = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{W{1'b0}}, sub};
	assign res   = total[W-1:0];
	assign cout  = total[W];

endmodule

>>> rtl/core/mrbs_accum.sv
// Per-pixel accumulation: count, budget check, min/max, sum, sum of squares.
module mrbs_accum #(
	parameter int SAMPLE_BITS = 16,
	parameter int COUNT_BITS  = 20
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [SAMPLE_BITS-1:0]         sample_value,
	input  logic                                  no_data,
	input  logic                                  last_pixel,
	input  logic [COUNT_BITS:0]                   budget,
	input  logic                                  clear,
	output mrbs_pkg::mrbs_ctl_t                   ctl,
	output logic [COUNT_BITS:0]                   good_count,
	output logic signed [SAMPLE_BITS-1:0]         run_min,
	output logic signed [SAMPLE_BITS-1:0]         run_max,
	output logic signed [SAMPLE_BITS+COUNT_BITS:0] run_sum,
	output logic [2*SAMPLE_BITS+COUNT_BITS-2:0]   run_sqsum
);
	import mrbs_pkg::*;

	localparam int CW   = COUNT_BITS + 1;
	localparam int SUMW = SAMPLE_BITS + CW;
	localparam int SQW  = 2 * SAMPLE_BITS - 1;
	localparam int SQSW = 2 * SAMPLE_BITS + COUNT_BITS - 1;

	typedef enum logic [3:0] {
		A_IDLE   = 4'b0001,
		A_SQUARE = 4'b0010,
		A_ADD    = 4'b0100,
		A_WAIT   = 4'b1000
	} acc_state_t;

	acc_state_t                    state_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic                          no_data_q;
	logic                          last_q;
	logic [CW-1:0]                 item_count_q;
	logic [CW-1:0]                 good_count_q;
	logic signed [SAMPLE_BITS-1:0] min_q;
	logic signed [SAMPLE_BITS-1:0] max_q;
	logic signed [SUMW-1:0]        sum_q;
	logic [SQSW-1:0]               sqsum_q;
	logic                          over_q;
	logic                          upd_q;
	logic [SQW-1:0]                sq_q;

	logic [SAMPLE_BITS-1:0]        mag;
	logic [2*SAMPLE_BITS-1:0]      prod;
	logic [CW-1:0]                 item_next;
	logic                          over_now;
	logic                          take;

	// magnitude and square of the held sample
	assign mag  = sample_q[SAMPLE_BITS-1] ? (~sample_q + 1'b1) : sample_q;
	assign prod = (2 * SAMPLE_BITS)'(mag) * (2 * SAMPLE_BITS)'(mag);

	// saturating item count and budget check
	assign item_next = (item_count_q == {CW{1'b1}}) ? item_count_q : item_count_q + CW'(1);
	assign over_now  = item_next > budget;
	assign take      = !over_now && !no_data_q;

	assign in_ready   = (state_q == A_IDLE);
	assign ctl.start  = (state_q == A_WAIT);
	assign ctl.over   = over_q;
	assign good_count = good_count_q;
	assign run_min    = min_q;
	assign run_max    = max_q;
	assign run_sum    = sum_q;
	assign run_sqsum  = sqsum_q;

	// held input word
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_q  <= sample_value;
			no_data_q <= no_data;
			last_q    <= last_pixel;
		end
		if (state_q == A_SQUARE) begin
			upd_q <= take;
			sq_q  <= prod[SQW-1:0];
		end
	end

	// sequencer and statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= A_IDLE;
			item_count_q <= '0;
			good_count_q <= '0;
			min_q        <= '0;
			max_q        <= '0;
			sum_q        <= '0;
			sqsum_q      <= '0;
			over_q       <= 1'b0;
		end else begin
			unique case (state_q)
				A_IDLE: begin
					if (in_valid) begin
						state_q <= A_SQUARE;
					end
				end
				A_SQUARE: begin
					item_count_q <= item_next;
					over_q       <= over_now;
					if (take) begin
						good_count_q <= good_count_q + CW'(1);
						if (good_count_q == '0) begin
							min_q <= sample_q;
							max_q <= sample_q;
						end else begin
							if (sample_q < min_q) min_q <= sample_q;
							if (sample_q > max_q) max_q <= sample_q;
						end
					end
					state_q <= A_ADD;
				end
				A_ADD: begin
					if (upd_q) begin
						sum_q   <= sum_q + SUMW'(sample_q);
						sqsum_q <= sqsum_q + SQSW'(sq_q);
					end
					state_q <= last_q ? A_WAIT : A_IDLE;
				end
				A_WAIT: begin
					// region closed: hold stats until the result is loaded into the output register, then clear
					if (clear) begin
						item_count_q <= '0;
						good_count_q <= '0;
						min_q        <= '0;
						max_q        <= '0;
						sum_q        <= '0;
						sqsum_q      <= '0;
						over_q       <= 1'b0;
						state_q      <= A_IDLE;
					end
				end
				default: state_q <= A_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/core/mrbs_finalize.sv
// Region result: mean, variance and square root, all through one add/sub unit.
// Multiplies are shift-add, divides are restoring, the root is digit by digit.
module mrbs_finalize #(
	parameter int SAMPLE_BITS = 16,
	parameter int COUNT_BITS  = 20
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  mrbs_pkg::mrbs_ctl_t                   ctl,
	input  logic [COUNT_BITS:0]                   n,
	input  logic signed [SAMPLE_BITS+COUNT_BITS:0] run_sum,
	input  logic [2*SAMPLE_BITS+COUNT_BITS-2:0]   run_sqsum,
	input  logic                                  out_free,
	output mrbs_pkg::mrbs_res_t                   res,
	output logic [SAMPLE_BITS+7:0]                mean_value,
	output logic [SAMPLE_BITS+7:0]                std_dev
);
	import mrbs_pkg::*;

	localparam int CW    = COUNT_BITS + 1;
	localparam int SUMW  = SAMPLE_BITS + CW;
	localparam int MAGW  = SAMPLE_BITS + COUNT_BITS;
	localparam int PW    = 2 * SAMPLE_BITS + 2 * COUNT_BITS - 1;
	localparam int DW    = PW + 16;
	localparam int VW    = 2 * SAMPLE_BITS + 15;
	localparam int RTW   = SAMPLE_BITS + 8;
	localparam int SRW   = VW + 1;
	localparam int ROOTN = SRW / 2;
	localparam int MDW   = MAGW + 8;
	localparam int RW    = (2 * COUNT_BITS + 2 > SAMPLE_BITS + 11) ?
	                       2 * COUNT_BITS + 2 : SAMPLE_BITS + 11;
	localparam int CNTW  = $clog2(DW + 1);

	typedef enum logic [8:0] {
		F_IDLE     = 9'b000000001,
		F_MEAN     = 9'b000000010,
		F_MUL_NS2  = 9'b000000100,
		F_MUL_S1SQ = 9'b000001000,
		F_VSUB     = 9'b000010000,
		F_MUL_NN   = 9'b000100000,
		F_VDIV     = 9'b001000000,
		F_SQRT     = 9'b010000000,
		F_OUT      = 9'b100000000
	} fin_state_t;

	fin_state_t       state_q;
	logic [CNTW-1:0]  cnt_q;
	logic [PW-1:0]    acc_q;
	logic [PW-1:0]    mcand_q;
	logic [MAGW-1:0]  mplier_q;
	logic [PW-1:0]    ns2_q;
	logic [DW-1:0]    dvd_q;
	logic [RW-1:0]    rem_q;
	logic [VW-1:0]    quo_q;
	logic [RTW-1:0]   mean_q;
	logic [RTW-1:0]   std_q;
	logic             zero_q;

	logic [SUMW-1:0]  sum_abs;
	logic [MAGW-1:0]  smag;
	logic [RW-1:0]    div_trial;
	logic [RW-1:0]    sq_trial;
	logic [PW-1:0]    ua;
	logic [PW-1:0]    ub;
	logic             usub;
	logic [PW-1:0]    ures;
	logic             ucout;
	logic             busy_step;

	assign sum_abs   = run_sum[SUMW-1] ? SUMW'(-run_sum) : SUMW'(run_sum);
	assign smag      = sum_abs[MAGW-1:0];
	assign div_trial = {rem_q[RW-2:0], dvd_q[DW-1]};
	assign sq_trial  = {rem_q[RW-3:0], dvd_q[DW-1:DW-2]};
	assign busy_step = (cnt_q != '0);

	// operand select for the shared unit
	always_comb begin
		ua   = '0;
		ub   = '0;
		usub = 1'b0;
		unique case (state_q)
			F_MUL_NS2, F_MUL_S1SQ, F_MUL_NN: begin
				ua = acc_q;
				ub = mcand_q;
			end
			F_MEAN: begin
				ua   = PW'(div_trial);
				ub   = PW'(n);
				usub = 1'b1;
			end
			F_VDIV: begin
				ua   = PW'(div_trial);
				ub   = acc_q;
				usub = 1'b1;
			end
			F_VSUB: begin
				ua   = ns2_q;
				ub   = acc_q;
				usub = 1'b1;
			end
			F_SQRT: begin
				ua   = PW'(sq_trial);
				ub   = PW'({quo_q[RTW-1:0], 2'b01});
				usub = 1'b1;
			end
			F_IDLE, F_OUT: begin
				usub = 1'b0;
			end
			default: usub = 1'b0;
		endcase
	end

	mrbs_addsub #(.W(PW)) u_addsub (
		.a    (ua),
		.b    (ub),
		.sub  (usub),
		.res  (ures),
		.cout (ucout)
	);

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			F_IDLE: begin
				if (ctl.start) begin
					zero_q <= ctl.over || (n == '0);
					dvd_q  <= DW'({smag, 8'b0}) << (DW - MDW);
					rem_q  <= '0;
					quo_q  <= '0;
				end
			end
			F_MEAN: begin
				if (busy_step) begin
					rem_q <= ucout ? ures[RW-1:0] : div_trial;
					quo_q <= {quo_q[VW-2:0], ucout};
					dvd_q <= dvd_q << 1;
				end else begin
					mean_q   <= run_sum[SUMW-1] ? (RTW'(0) - quo_q[RTW-1:0]) : quo_q[RTW-1:0];
					acc_q    <= '0;
					mcand_q  <= PW'(run_sqsum);
					mplier_q <= MAGW'(n);
				end
			end
			F_MUL_NS2, F_MUL_S1SQ, F_MUL_NN: begin
				if (busy_step) begin
					if (mplier_q[0]) acc_q <= ures;
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
				end else if (state_q == F_MUL_NS2) begin
					ns2_q    <= acc_q;
					acc_q    <= '0;
					mcand_q  <= PW'(smag);
					mplier_q <= smag;
				end else if (state_q == F_MUL_NN) begin
					rem_q <= '0;
					quo_q <= '0;
				end
			end
			F_VSUB: begin
				// n*sumsq - sum^2, scaled by 2^16; a negative difference means zero
				dvd_q    <= ucout ? {ures, 16'b0} : '0;
				acc_q    <= '0;
				mcand_q  <= PW'(n);
				mplier_q <= MAGW'(n);
			end
			F_VDIV: begin
				if (busy_step) begin
					rem_q <= ucout ? ures[RW-1:0] : div_trial;
					quo_q <= {quo_q[VW-2:0], ucout};
					dvd_q <= dvd_q << 1;
				end else begin
					dvd_q <= DW'({1'b0, quo_q}) << (DW - SRW);
					rem_q <= '0;
					quo_q <= '0;
				end
			end
			F_SQRT: begin
				if (busy_step) begin
					rem_q <= ucout ? ures[RW-1:0] : sq_trial;
					quo_q <= {quo_q[VW-2:0], ucout};
					dvd_q <= dvd_q << 2;
				end else begin
					std_q <= quo_q[RTW-1:0];
				end
			end
			F_OUT: begin
				zero_q <= zero_q;
			end
			default: zero_q <= zero_q;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			if (busy_step) begin
				cnt_q <= cnt_q - CNTW'(1);
			end
			unique case (state_q)
				F_IDLE: begin
					if (ctl.start) begin
						if (ctl.over || (n == '0)) begin
							state_q <= F_OUT;
						end else begin
							cnt_q   <= CNTW'(MDW);
							state_q <= F_MEAN;
						end
					end
				end
				F_MEAN: begin
					if (!busy_step) begin
						cnt_q   <= CNTW'(CW);
						state_q <= F_MUL_NS2;
					end
				end
				F_MUL_NS2: begin
					if (!busy_step) begin
						cnt_q   <= CNTW'(MAGW);
						state_q <= F_MUL_S1SQ;
					end
				end
				F_MUL_S1SQ: begin
					if (!busy_step) state_q <= F_VSUB;
				end
				F_VSUB: begin
					cnt_q   <= CNTW'(CW);
					state_q <= F_MUL_NN;
				end
				F_MUL_NN: begin
					if (!busy_step) begin
						cnt_q   <= CNTW'(DW);
						state_q <= F_VDIV;
					end
				end
				F_VDIV: begin
					if (!busy_step) begin
						cnt_q   <= CNTW'(ROOTN);
						state_q <= F_SQRT;
					end
				end
				F_SQRT: begin
					if (!busy_step) state_q <= F_OUT;
				end
				F_OUT: begin
					if (out_free) state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	assign res.load   = (state_q == F_OUT) && out_free;
	assign res.zero   = zero_q;
	assign mean_value = mean_q;
	assign std_dev    = std_q;

endmodule

>>> rtl/core/mrbs_checker.sv
`include "masked_region_band_statistics_defines.svh"

// Port-level checks on the statistics block.
module mrbs_checker #(
	parameter int SAMPLE_BITS = mrbs_pkg::SAMPLE_BITS_DEF,
	parameter int COUNT_BITS  = mrbs_pkg::COUNT_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic [mrbs_pkg::byte_width(COUNT_BITS + 1 + 4 * SAMPLE_BITS + 16)-1:0] m_tdata,
	input logic m_tuser,
	input logic m_tvalid,
	input logic m_tready
);
	import mrbs_pkg::*;

	localparam int CW     = COUNT_BITS + 1;
	localparam int MIN_LO = CW;
	localparam int MAX_LO = CW + SAMPLE_BITS;

	logic [CW-1:0]                 o_count;
	logic signed [SAMPLE_BITS-1:0] o_min;
	logic signed [SAMPLE_BITS-1:0] o_max;

	assign o_count = m_tdata[CW-1:0];
	assign o_min   = m_tdata[MIN_LO+SAMPLE_BITS-1:MIN_LO];
	assign o_max   = m_tdata[MAX_LO+SAMPLE_BITS-1:MAX_LO];

	// a pixel word keeps the block busy for the following cycle
	`MRBS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready right after a pixel word")

	// stalled result word holds
	`MRBS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed under stall")

	// over-budget results carry no statistics
	`MRBS_ASSERT_IMPL(a_over_zero, m_tvalid && m_tuser, m_tdata == '0, "over-budget result has statistics")

	// extremes are ordered whenever any pixel counted
	`MRBS_ASSERT_IMPL(a_min_le_max, m_tvalid && (o_count != '0), o_min <= o_max, "min above max")

endmodule

bind masked_region_band_statistics mrbs_checker #(
	.SAMPLE_BITS (SAMPLE_BITS),
	.COUNT_BITS  (COUNT_BITS)
) u_mrbs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready)
);

>>> sim/masked_region_band_statistics_tb.sv
`timescale 1ns / 100ps

module masked_region_band_statistics_tb;

	localparam int SB = mrbs_pkg::SAMPLE_BITS_DEF;
	localparam int CB = mrbs_pkg::COUNT_BITS_DEF;
	localparam int IN_W = mrbs_pkg::byte_width(SB);
	localparam int OUT_W = mrbs_pkg::byte_width(CB + 1 + 4 * SB + 16);

	// result word layout, lowest bit up
	localparam int CNT_LO = 0;
	localparam int MIN_LO = CNT_LO + CB + 1;
	localparam int MAX_LO = MIN_LO + SB;
	localparam int MEAN_LO = MAX_LO + SB;
	localparam int STD_LO = MEAN_LO + SB + 8;

	localparam logic [CB:0] BUDGET_FULL = 1 << CB;
	localparam longint ITEM_CAP = (64'd1 << (CB + 1)) - 1;
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES = 300;

	typedef struct packed {
		logic signed [SB-1:0] value;
		logic no_data;
		logic last;
	} pixel_t;

	typedef struct packed {
		logic status;
		logic [CB:0] count;
		logic signed [SB-1:0] min_v;
		logic signed [SB-1:0] max_v;
		logic signed [SB+7:0] mean;
		logic [SB+7:0] stdev;
	} region_stats_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic [IN_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic s_tlast = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [OUT_W-1:0] m_tdata;
	logic m_tuser;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [CB:0] cfg_data = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;

	masked_region_band_statistics dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cfg_data(cfg_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready)
	);

	always #4 clk = ~clk;

	pixel_t pending[$];
	region_stats_t stats_due[$];
	int unsigned errors = 0;
	int unsigned cycle_no = 0;

	// predictor copy of the block state
	logic [CB:0] budget_reg = BUDGET_FULL;
	longint pix_seen = 0;
	longint good_seen = 0;
	logic signed [SB-1:0] lo_v = '0;
	logic signed [SB-1:0] hi_v = '0;
	longint sum_v = 0;
	logic [63:0] sq_sum = '0;

	// both sides skip the random idling in this window
	function automatic logic quiet_window(input int unsigned cyc);
		return cyc >= 3000 && cyc < 6000;
	endfunction

	function automatic logic [63:0] root_floor(input logic [127:0] x);
		logic [63:0] r;
		logic [63:0] t;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if ({64'd0, t} * {64'd0, t} <= x) r = t;
		end
		return r;
	endfunction

	// fold one accepted pixel word into the region state, queue stats on last
	task automatic fold_pixel(input pixel_t p);
		logic [CB:0] lim;
		logic over;
		logic [63:0] mag;
		logic [63:0] smag;
		logic [63:0] mq;
		logic [63:0] mean_full;
		logic [63:0] root;
		logic [127:0] n;
		logic [127:0] ns2;
		logic [127:0] s1sq;
		logic [127:0] var16;
		region_stats_t r;
		lim = (budget_reg == 0 || budget_reg > BUDGET_FULL) ? BUDGET_FULL : budget_reg;
		if (pix_seen < ITEM_CAP) pix_seen++;
		over = pix_seen > lim;
		if (!over && !p.no_data) begin
			if (good_seen == 0) begin
				lo_v = p.value;
				hi_v = p.value;
			end else begin
				if (p.value < lo_v) lo_v = p.value;
				if (p.value > hi_v) hi_v = p.value;
			end
			sum_v += longint'(p.value);
			mag = (p.value < 0) ? -longint'(p.value) : longint'(p.value);
			sq_sum += mag * mag;
			good_seen++;
		end
		if (!p.last) return;
		r = '0;
		r.status = over;
		if (!over && good_seen > 0) begin
			n = good_seen;
			smag = (sum_v < 0) ? -sum_v : sum_v;
			mq = (smag << 8) / n[63:0];
			mean_full = (sum_v < 0) ? 64'd0 - mq : mq;
			ns2 = n * {64'd0, sq_sum};
			s1sq = {64'd0, smag} * {64'd0, smag};
			var16 = '0;
			if (ns2 >= s1sq) var16 = ((ns2 - s1sq) << 16) / (n * n);
			root = root_floor(var16);
			r.count = good_seen[CB:0];
			r.min_v = lo_v;
			r.max_v = hi_v;
			r.mean = mean_full[SB+7:0];
			r.stdev = root[SB+7:0];
		end
		stats_due.push_back(r);
		pix_seen = 0;
		good_seen = 0;
		lo_v = '0;
		hi_v = '0;
		sum_v = 0;
		sq_sum = '0;
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	// pixel driver
	pixel_t in_word;
	pixel_t next_word;
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				in_word.value = s_tdata[SB-1:0];
				in_word.no_data = s_tuser;
				in_word.last = s_tlast;
				fold_pixel(in_word);
			end
			if (!s_tvalid || s_tready) begin
				if (pending.size() != 0 &&
						(quiet_window(cycle_no) || $urandom_range(99) >= 20)) begin
					next_word = pending.pop_front();
					s_tdata <= IN_W'(next_word.value);
					s_tuser <= next_word.no_data;
					s_tlast <= next_word.last;
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor with random backpressure and occasional long hold-off
	region_stats_t got_word;
	region_stats_t want_word;
	int unsigned results_seen = 0;
	int unsigned next_hold_at = 25;
	int unsigned hold_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got_word.status = m_tuser;
				got_word.count = m_tdata[CNT_LO +: CB + 1];
				got_word.min_v = m_tdata[MIN_LO +: SB];
				got_word.max_v = m_tdata[MAX_LO +: SB];
				got_word.mean = m_tdata[MEAN_LO +: SB + 8];
				got_word.stdev = m_tdata[STD_LO +: SB + 8];
				if (stats_due.size() == 0) begin
					report_mismatch("result word with none pending, valid_count",
						got_word.count, 0);
				end else begin
					want_word = stats_due.pop_front();
					if (got_word.status !== want_word.status)
						report_mismatch("status", got_word.status, want_word.status);
					if (got_word.count !== want_word.count)
						report_mismatch("valid_count", got_word.count, want_word.count);
					if (got_word.min_v !== want_word.min_v)
						report_mismatch("min_value", got_word.min_v, want_word.min_v);
					if (got_word.max_v !== want_word.max_v)
						report_mismatch("max_value", got_word.max_v, want_word.max_v);
					if (got_word.mean !== want_word.mean)
						report_mismatch("mean_value", got_word.mean, want_word.mean);
					if (got_word.stdev !== want_word.stdev)
						report_mismatch("std_dev", got_word.stdev, want_word.stdev);
				end
				results_seen++;
				// stall the output while plenty of pixels are still queued
				if (results_seen >= next_hold_at && pending.size() > 40) begin
					hold_left = HOLD_CYCLES;
					next_hold_at = results_seen + 40;
				end
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= quiet_window(cycle_no) || $urandom_range(99) >= 20;
			end
		end
	end

	// watchdog on cycles with no word moving anywhere
	int unsigned stall_cycles = 0;
	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("masked_region_band_statistics verification failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic push_pixel(input int v, input bit nd, input bit last);
		pixel_t p;
		p.value = SB'(v);
		p.no_data = nd;
		p.last = last;
		pending.push_back(p);
	endtask

	// one region with random length-independent content style
	task automatic push_region(input int len);
		int style;
		int fixed_v;
		int v;
		int pick;
		style = $urandom_range(3);
		fixed_v = $urandom_range(65535) - 32768;
		for (int i = 0; i < len; i++) begin
			pick = $urandom_range(4);
			case (style)
				0: v = $urandom_range(65535) - 32768;
				1: v = (pick == 0) ? 32767 : (pick == 1) ? -32768 :
					(pick == 2) ? 0 : (pick == 3) ? -1 : 1;
				2: v = $urandom_range(16) - 8;
				default: v = fixed_v;
			endcase
			push_pixel(v, $urandom_range(99) < 15, i == len - 1);
		end
	endtask

	function automatic int region_len();
		int r;
		r = $urandom_range(99);
		if (r < 70) return $urandom_range(8, 1);
		if (r < 95) return $urandom_range(30, 9);
		return $urandom_range(120, 31);
	endfunction

	// wait until every queued pixel went in and every region came out
	task automatic settle();
		do @(negedge clk);
		while (pending.size() != 0 || s_tvalid || stats_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_budget(input logic [CB:0] v);
		@(posedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		budget_reg = v;
		@(negedge clk);
	endtask

	logic [CB:0] budgets[9];
	int filled;
	initial begin
		budgets = '{21'd1, 21'd7, 21'd0, 21'h1FFFFF, 21'h100000, 21'h100001, 21'd20,
			21'd0, 21'd0};
		budgets[7] = $urandom_range(30, 1);
		budgets[8] = $urandom_range(64, 2);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed regions at the reset budget
		push_pixel(32767, 0, 1);
		push_pixel(-32768, 0, 1);
		push_pixel(-32768, 0, 0);
		push_pixel(32767, 0, 1);
		// all no-data
		push_pixel(5, 1, 0);
		push_pixel(-1, 1, 1);
		// negative mean, truncated toward zero
		push_pixel(100, 1, 0);
		push_pixel(-1, 0, 0);
		push_pixel(-1, 0, 0);
		push_pixel(0, 0, 1);
		// last word is no-data
		push_pixel(0, 0, 0);
		push_pixel(7, 1, 1);
		push_pixel(32767, 0, 0);
		push_pixel(32767, 0, 0);
		push_pixel(32767, 0, 0);
		push_pixel(-32768, 0, 1);
		for (int i = 1; i <= 5; i++) push_pixel(i, 0, i == 5);
		push_pixel(-7, 0, 0);
		push_pixel(7, 0, 0);
		push_pixel(123, 0, 1);
		settle();

		for (int ph = 0; ph < 9; ph++) begin
			write_budget(budgets[ph]);
			if (ph == 0) begin
				// over budget, incl. region ending on a no-data word
				push_pixel(5, 0, 1);
				push_pixel(5, 0, 0);
				push_pixel(6, 0, 1);
				push_pixel(3, 1, 0);
				push_pixel(3, 0, 1);
				push_pixel(-3, 0, 0);
				push_pixel(-3, 0, 0);
				push_pixel(-3, 1, 1);
			end
			filled = 0;
			while (filled < 85) begin
				int len;
				len = region_len();
				push_region(len);
				filled += len;
			end
			settle();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (stats_due.size() != 0)
			report_mismatch("regions with no result word", 0, stats_due.size());
		if (errors == 0) begin
			$display("masked_region_band_statistics verification clean");
		end else begin
			$display("masked_region_band_statistics verification failed");
		end
		$finish;
	end

endmodule
